### hdl/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

	// history window
	localparam int HIST_DEPTH = 4096;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// token format
	localparam logic [4:0] REF_LEN_BIAS    = 5'd3;
	localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;

	// configuration map
	localparam int          CFG_AW          = 3;
	localparam logic [0:0]  REG_HALFWORD    = 1'b0;

	// one write request and one read request to the history memory
	typedef struct packed {
		logic               we;
		logic [HIST_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [HIST_AW-1:0] raddr;
	} hist_req_t;

endpackage

### hdl/lzd_history.sv
`timescale 1ns / 1ps

module lzd_history (
	input  logic                 clk,
	input  lzd_pkg::hist_req_t   req,
	output logic [7:0]           rd_byte
);

	logic [7:0] mem_q [lzd_pkg::HIST_DEPTH];
	logic [7:0] rdata_q;
	logic [7:0] fwd_byte_q;
	logic       fwd_q;

	// single write port, single registered read port; a read of the entry
	// written in the same cycle takes the new byte through the bypass
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q    <= mem_q[req.raddr];
			fwd_q      <= req.we && (req.waddr == req.raddr);
			fwd_byte_q <= req.wdata;
		end
	end

	assign rd_byte = fwd_q ? fwd_byte_q : rdata_q;

endmodule

### hdl/lzd_ctrl.sv
`timescale 1ns / 1ps

module lzd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	// compressed stream
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_start,
	// decompressed stream
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          out_data,
	output logic                 out_last,
	// configuration
	input  logic                 halfword,
	input  logic                 cfg_wr,
	// history memory
	output lzd_pkg::hist_req_t   hist_req,
	input  logic [7:0]           hist_byte
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FLAG,
		PH_TOKEN,
		PH_REFLO
	} phase_t;

	typedef enum logic [1:0] {
		ST_READY,
		ST_LIT,
		ST_COPY
	} state_t;

	state_t                      state_q;
	phase_t                      phase_q;
	logic [2:0]                  hdr_cnt_q;
	logic [23:0]                 remain_q;
	logic [7:0]                  flags_q;
	logic [3:0]                  tok_left_q;
	logic [7:0]                  ref_hi_q;
	logic [7:0]                  pend_byte_q;
	logic                        pend_valid_q;
	logic [lzd_pkg::HIST_AW-1:0] hist_ptr_q;
	logic [lzd_pkg::HIST_AW-1:0] src_q;
	logic [4:0]                  copy_cnt_q;
	logic [7:0]                  lit_q;
	logic                        out_valid_q;
	logic [15:0]                 out_data_q;
	logic                        out_last_q;

	logic                        accept;
	logic                        ref_accept;
	logic [lzd_pkg::HIST_AW-1:0] src_new;
	logic [3:0]                  tok_left_dec;
	logic                        emit_byte_live;
	logic [7:0]                  emit_byte;
	logic                        emit_produce;
	logic                        emit_fire;
	logic                        remain_last;
	logic                        copy_more;

	assign accept     = in_valid && in_ready;
	assign in_ready   = (state_q == ST_READY);
	assign ref_accept = accept && !in_start && (phase_q == PH_REFLO);
	assign src_new    = hist_ptr_q - {ref_hi_q[3:0], in_byte} - 1'b1;
	assign tok_left_dec = tok_left_q - 1'b1;

	// shared emit path: literals and copied bytes both pass through here
	assign emit_byte_live = (state_q == ST_LIT) || (state_q == ST_COPY);
	assign emit_byte      = (state_q == ST_LIT) ? lit_q : hist_byte;
	assign emit_produce   = !halfword || pend_valid_q;
	assign emit_fire      = emit_byte_live &&
		(!emit_produce || !out_valid_q || out_ready);
	assign remain_last    = (remain_q == 24'd1);
	assign copy_more      = (state_q == ST_COPY) && (copy_cnt_q != 5'd1) && !remain_last;

	// history requests
	always_comb begin
		hist_req.we    = emit_fire;
		hist_req.waddr = hist_ptr_q;
		hist_req.wdata = emit_byte;
		hist_req.re    = ref_accept || (emit_fire && copy_more);
		hist_req.raddr = ref_accept ? src_new : src_q;
	end

	// parser, sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_READY;
			phase_q      <= PH_HEADER;
			hdr_cnt_q    <= '0;
			remain_q     <= '0;
			flags_q      <= '0;
			tok_left_q   <= '0;
			ref_hi_q     <= '0;
			pend_byte_q  <= '0;
			pend_valid_q <= 1'b0;
			hist_ptr_q   <= '0;
			src_q        <= '0;
			copy_cnt_q   <= '0;
			lit_q        <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				pend_valid_q <= 1'b0;
			end

			// token parsing on an accepted byte
			if (accept) begin
				if (in_start) begin
					phase_q      <= PH_HEADER;
					hdr_cnt_q    <= 3'd1;
					remain_q     <= '0;
					pend_valid_q <= 1'b0;
				end else begin
					unique case (phase_q)
						PH_HEADER: begin
							if (hdr_cnt_q != 3'd4) begin
								hdr_cnt_q <= hdr_cnt_q + 1'b1;
								case (hdr_cnt_q)
									3'd0: remain_q          <= '0;
									3'd1: remain_q[7:0]     <= in_byte;
									3'd2: remain_q[15:8]    <= in_byte;
									default: begin
										remain_q[23:16] <= in_byte;
										pend_valid_q    <= 1'b0;
										if ((remain_q[15:0] != 16'd0) || (in_byte != 8'd0)) begin
											phase_q <= PH_FLAG;
										end
									end
								endcase
							end
						end
						PH_FLAG: begin
							flags_q    <= in_byte;
							tok_left_q <= lzd_pkg::TOKENS_PER_FLAG;
							phase_q    <= PH_TOKEN;
						end
						PH_TOKEN: begin
							if (flags_q[7]) begin
								ref_hi_q <= in_byte;
								phase_q  <= PH_REFLO;
							end else begin
								flags_q    <= {flags_q[6:0], 1'b0};
								tok_left_q <= tok_left_dec;
								phase_q    <= (tok_left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
								lit_q      <= in_byte;
								state_q    <= ST_LIT;
							end
						end
						PH_REFLO: begin
							flags_q    <= {flags_q[6:0], 1'b0};
							tok_left_q <= tok_left_dec;
							phase_q    <= (tok_left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
							copy_cnt_q <= {1'b0, ref_hi_q[7:4]} + lzd_pkg::REF_LEN_BIAS;
							src_q      <= src_new + 1'b1;
							state_q    <= ST_COPY;
						end
						default: ;
					endcase
				end
			end

			// one decompressed byte per cycle, unless a full output word waits on out_ready
			if (emit_fire) begin
				hist_ptr_q <= hist_ptr_q + 1'b1;
				remain_q   <= remain_q - 1'b1;
				if (halfword) begin
					if (pend_valid_q) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= {emit_byte, pend_byte_q};
						out_last_q   <= (remain_q <= 24'd2);
						pend_valid_q <= 1'b0;
					end else begin
						pend_byte_q  <= emit_byte;
						pend_valid_q <= 1'b1;
					end
				end else begin
					out_valid_q <= 1'b1;
					out_data_q  <= {8'd0, emit_byte};
					out_last_q  <= remain_last;
				end
				if (copy_more) begin
					copy_cnt_q <= copy_cnt_q - 1'b1;
					src_q      <= src_q + 1'b1;
				end else begin
					state_q <= ST_READY;
				end
				// end of stream: wait for the next start
				if (remain_last) begin
					phase_q      <= PH_HEADER;
					hdr_cnt_q    <= 3'd4;
					pend_valid_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

### hdl/lz77_stream_decompressor_unit.sv
`timescale 1ns / 1ps

// LZ77 stream decompressor. Compressed bytes enter one byte at a time on the
// slave side: a 4-byte little-endian header (bits 31:8 give the output
// length), then flag bytes each governing eight literal or back-reference
// tokens over a 4096-byte history. Header, flag and reference high bytes
// are parsed as accepted; a literal is accepted, then emitted; a reference's
// low byte issues the first history read, then its copied bytes (3 to 18,
// fewer at the end of the stream) are emitted in turn. s_tready is low while
// a byte is emitted, and an output word held by m_tready low stalls an emit
// that completes a word. The history memory is not cleared after reset, so
// there is no start-up pass; stream_start (tuser) restarts the header parse
// without touching history. Register 0 (halfword_output) selects 16-bit
// results holding byte pairs, low byte first.

module lz77_stream_decompressor_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// compressed input
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] stream_byte
	input  logic                       s_tuser,   // [0] stream_start
	// decompressed output
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,   // [15:0] out_data
	output logic                       m_tlast,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lzd_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	lzd_pkg::hist_req_t hist_req;
	logic [7:0]         hist_byte;
	logic               halfword_q;
	logic               cfg_wr;

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[lzd_pkg::CFG_AW-1] == lzd_pkg::REG_HALFWORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halfword_q <= 1'b0;
		end else if (cfg_wr) begin
			halfword_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[lzd_pkg::CFG_AW-1] == lzd_pkg::REG_HALFWORD) ?
		{31'd0, halfword_q} : 32'd0;

	lzd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_start  (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.halfword  (halfword_q),
		.cfg_wr    (cfg_wr),
		.hist_req  (hist_req),
		.hist_byte (hist_byte)
	);

	lzd_history u_history (
		.clk     (clk),
		.req     (hist_req),
		.rd_byte (hist_byte)
	);

	// history is only written while an item is being worked on
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hist_req.we |-> !s_tready)
		else $error("history write while input side ready");

	// a history read is always followed by a copy cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hist_req.re |=> !s_tready)
		else $error("history read not followed by copy");

	// every new output word comes from a byte just written to history
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(hist_req.we))
		else $error("output word without emitted byte");

endmodule
